@@ hw/rtl/rect_zone_snap_resolver_assert.svh @@
// Assertion macros used by the rect zone snap resolver core.
`ifndef RECT_ZONE_SNAP_RESOLVER_ASSERT_SVH
`define RECT_ZONE_SNAP_RESOLVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RZSR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rect_zone_snap_resolver: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RZSR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rect_zone_snap_resolver: next-cycle check failed");

`endif

@@ hw/rtl/rzsr_pkg.sv @@
// Types, constants and codes shared by the rect zone snap resolver modules.
package rzsr_pkg;

   localparam int ZONES_DEF   = 16;
   localparam int COUNT_W     = 5;
   localparam int PT_W        = 12;
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_COUNT = 2'd2;

   localparam logic signed [PT_W-1:0] PT_NONE_A = -12'sd1;
   localparam logic signed [PT_W-1:0] PT_NONE_B = -12'sd2;
   localparam logic signed [PT_W:0]   OUT_MAX   = 13'sd2047;
   localparam logic signed [PT_W:0]   OUT_MIN   = -13'sd2048;

   typedef struct packed {
      logic [10:0] height;
      logic [10:0] width;
      logic [9:0]  top;
      logic [9:0]  left;
   } box_type;

   typedef struct packed {
      logic [9:0] tgt_y;
      logic [9:0] tgt_x;
      logic [7:0] prio;
      box_type    box;
   } zone_rec_type;

   typedef struct packed {
      logic [11:0]        x0;
      logic [11:0]        y0;
      logic [11:0]        x1;
      logic [11:0]        y1;
      logic signed [12:0] px;
      logic signed [12:0] py;
   } geom_req_type;

   typedef struct packed {
      logic       idle;
      logic       done;
      logic       found;
      logic [3:0] slot;
      logic [9:0] tgt_x;
      logic [9:0] tgt_y;
   } core_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P1,
      ST_P2_SCAN,
      ST_P2_OVL,
      ST_P2_SPL,
      ST_P2_DEC,
      ST_FIN
   } state_type;

endpackage

@@ hw/rtl/rzsr_zone_mem.sv @@
// Zone table memory with one write port and one registered read port.
module rzsr_zone_mem #(
   parameter int ZONES = rzsr_pkg::ZONES_DEF,
   localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IW-1:0]          wr_addr,
   input  rzsr_pkg::zone_rec_type wr_data,
   input  logic                   rd_en,
   input  logic [IW-1:0]          rd_addr,
   output rzsr_pkg::zone_rec_type rd_data
);

   rzsr_pkg::zone_rec_type zone_mem_ff [ZONES];
   rzsr_pkg::zone_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         zone_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= zone_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rzsr_geom.sv @@
// Shared compare unit: tests whether a point lies inside a half-open box.
module rzsr_geom (
   input  rzsr_pkg::geom_req_type q,
   output logic                   hit
);

   logic signed [12:0] x0_s;
   logic signed [12:0] y0_s;
   logic signed [12:0] x1_s;
   logic signed [12:0] y1_s;

   assign x0_s = $signed({1'b0, q.x0});
   assign y0_s = $signed({1'b0, q.y0});
   assign x1_s = $signed({1'b0, q.x1});
   assign y1_s = $signed({1'b0, q.y1});

   assign hit = ($signed(q.px) >= x0_s) && ($signed(q.px) < x1_s) &&
                ($signed(q.py) >= y0_s) && ($signed(q.py) < y1_s);

endmodule

@@ hw/rtl/rzsr_core.sv @@
// Query sequencer: candidate scan, owner choice and overlap resolution.
module rzsr_core #(
   parameter int ZONES = rzsr_pkg::ZONES_DEF,
   localparam int CW = ($clog2(ZONES + 1) > rzsr_pkg::COUNT_W) ?
                       $clog2(ZONES + 1) : rzsr_pkg::COUNT_W,
   localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [12:0]      rx,
   input  logic signed [12:0]      ry,
   input  logic [CW-1:0]           limit,
   input  logic                    take,
   output logic                    rd_en,
   output logic [IW-1:0]           rd_addr,
   input  rzsr_pkg::zone_rec_type  rd_data,
   output rzsr_pkg::core_stat_type stat
);

`include "rect_zone_snap_resolver_assert.svh"

   typedef struct packed {
      logic [11:0] x0;
      logic [11:0] y0;
      logic [11:0] x1;
      logic [11:0] y1;
   } ovl_type;

   rzsr_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          limit_ff, limit_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IW-1:0]          chk_idx_ff, chk_idx_in;
   logic [ZONES-1:0]       cand_ff, cand_in;
   logic                   have_ff, have_in;
   logic [IW-1:0]          own_idx_ff, own_idx_in;
   rzsr_pkg::zone_rec_type own_ff, own_in;
   logic signed [12:0]     rx_ff, rx_in;
   logic signed [12:0]     ry_ff, ry_in;
   ovl_type                ovl_ff, ovl_in;
   logic                   hit_ff, hit_in;
   logic                   xsplit_ff, xsplit_in;
   logic [11:0]            mid_ff, mid_in;

   logic                  idx_lt;
   logic [IW-1:0]         cur_idx;
   rzsr_pkg::geom_req_type geom_q;
   logic                  geom_hit;
   logic [11:0]           end_cx, end_cy, end_ox, end_oy;
   logic [11:0]           ow, oh;
   logic signed [12:0]    coord;
   logic                  far_side;
   logic [9:0]            edge_c, edge_o;
   logic                  win;

   assign idx_lt  = idx_ff < limit_ff;
   assign cur_idx = idx_ff[IW-1:0];

   assign end_cx = {2'b00, rd_data.box.left} + {1'b0, rd_data.box.width};
   assign end_cy = {2'b00, rd_data.box.top} + {1'b0, rd_data.box.height};
   assign end_ox = {2'b00, own_ff.box.left} + {1'b0, own_ff.box.width};
   assign end_oy = {2'b00, own_ff.box.top} + {1'b0, own_ff.box.height};

   always_comb begin
      geom_q.px = rx_ff;
      geom_q.py = ry_ff;
      if (state_ff == rzsr_pkg::ST_P2_SPL) begin
         geom_q.x0 = ovl_ff.x0;
         geom_q.y0 = ovl_ff.y0;
         geom_q.x1 = ovl_ff.x1;
         geom_q.y1 = ovl_ff.y1;
      end else begin
         geom_q.x0 = {2'b00, rd_data.box.left};
         geom_q.y0 = {2'b00, rd_data.box.top};
         geom_q.x1 = end_cx;
         geom_q.y1 = end_cy;
      end
   end

   rzsr_geom u_geom (
      .q   (geom_q),
      .hit (geom_hit)
   );

   assign ow       = ovl_ff.x1 - ovl_ff.x0;
   assign oh       = ovl_ff.y1 - ovl_ff.y0;
   assign coord    = xsplit_ff ? rx_ff : ry_ff;
   assign far_side = coord >= $signed({1'b0, mid_ff});
   assign edge_c   = xsplit_ff ? rd_data.box.left : rd_data.box.top;
   assign edge_o   = xsplit_ff ? own_ff.box.left : own_ff.box.top;
   assign win      = far_side ? (edge_c > edge_o) : (edge_c < edge_o);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rzsr_pkg::ST_IDLE;
         chk_vld_ff <= 1'b0;
         cand_ff    <= '0;
         have_ff    <= 1'b0;
         idx_ff     <= '0;
         limit_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         cand_ff    <= cand_in;
         have_ff    <= have_in;
         idx_ff     <= idx_in;
         limit_ff   <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      own_idx_ff <= own_idx_in;
      own_ff     <= own_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      ovl_ff     <= ovl_in;
      hit_ff     <= hit_in;
      xsplit_ff  <= xsplit_in;
      mid_ff     <= mid_in;
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      limit_in   = limit_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      cand_in    = cand_ff;
      have_in    = have_ff;
      own_idx_in = own_idx_ff;
      own_in     = own_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      ovl_in     = ovl_ff;
      hit_in     = hit_ff;
      xsplit_in  = xsplit_ff;
      mid_in     = mid_ff;
      rd_en      = 1'b0;
      rd_addr    = cur_idx;
      unique case (state_ff)
         rzsr_pkg::ST_IDLE: begin
            if (start) begin
               rx_in    = rx;
               ry_in    = ry;
               limit_in = limit;
               idx_in   = '0;
               cand_in  = '0;
               have_in  = 1'b0;
               state_in = rzsr_pkg::ST_P1;
            end
         end
         rzsr_pkg::ST_P1: begin
            if (idx_lt) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = cur_idx;
               idx_in     = idx_ff + CW'(1);
            end
            if (chk_vld_ff && geom_hit) begin
               cand_in[chk_idx_ff] = 1'b1;
               if (!have_ff || (rd_data.prio > own_ff.prio)) begin
                  have_in    = 1'b1;
                  own_idx_in = chk_idx_ff;
                  own_in     = rd_data;
               end
            end
            if (!idx_lt && !chk_vld_ff) begin
               idx_in   = '0;
               state_in = have_ff ? rzsr_pkg::ST_P2_SCAN : rzsr_pkg::ST_FIN;
            end
         end
         rzsr_pkg::ST_P2_SCAN: begin
            if (!idx_lt) begin
               state_in = rzsr_pkg::ST_FIN;
            end else if (cand_ff[cur_idx] && (cur_idx != own_idx_ff)) begin
               rd_en    = 1'b1;
               state_in = rzsr_pkg::ST_P2_OVL;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         rzsr_pkg::ST_P2_OVL: begin
            if (rd_data.prio != own_ff.prio) begin
               idx_in   = idx_ff + CW'(1);
               state_in = rzsr_pkg::ST_P2_SCAN;
            end else begin
               ovl_in.x0 = (rd_data.box.left > own_ff.box.left) ?
                           {2'b00, rd_data.box.left} : {2'b00, own_ff.box.left};
               ovl_in.y0 = (rd_data.box.top > own_ff.box.top) ?
                           {2'b00, rd_data.box.top} : {2'b00, own_ff.box.top};
               ovl_in.x1 = (end_cx < end_ox) ? end_cx : end_ox;
               ovl_in.y1 = (end_cy < end_oy) ? end_cy : end_oy;
               state_in  = rzsr_pkg::ST_P2_SPL;
            end
         end
         rzsr_pkg::ST_P2_SPL: begin
            hit_in    = geom_hit;
            xsplit_in = ow > oh;
            mid_in    = (ow > oh) ? (ovl_ff.x0 + {1'b0, ow[11:1]}) :
                                    (ovl_ff.y0 + {1'b0, oh[11:1]});
            state_in  = rzsr_pkg::ST_P2_DEC;
         end
         rzsr_pkg::ST_P2_DEC: begin
            if (hit_ff && win) begin
               own_idx_in = cur_idx;
               own_in     = rd_data;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = rzsr_pkg::ST_P2_SCAN;
         end
         rzsr_pkg::ST_FIN: begin
            if (take) begin
               state_in = rzsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rzsr_pkg::ST_IDLE;
         end
      endcase
   end

   assign stat.idle  = state_ff == rzsr_pkg::ST_IDLE;
   assign stat.done  = state_ff == rzsr_pkg::ST_FIN;
   assign stat.found = have_ff;
   assign stat.slot  = 4'(own_idx_ff);
   assign stat.tgt_x = own_ff.tgt_x;
   assign stat.tgt_y = own_ff.tgt_y;

   `RZSR_ASSERT_IMP(a_start_only_idle, start, state_ff == rzsr_pkg::ST_IDLE)
   `RZSR_ASSERT_NXT(a_fin_waits_take, (state_ff == rzsr_pkg::ST_FIN) && !take,
                    state_ff == rzsr_pkg::ST_FIN)
   `RZSR_ASSERT_IMP(a_owner_is_cand, have_ff, cand_ff[own_idx_ff])
   `RZSR_ASSERT_IMP(a_idx_in_range, state_ff != rzsr_pkg::ST_IDLE, idx_ff <= limit_ff)

endmodule

@@ hw/rtl/rect_zone_snap_resolver.sv @@
// Top level of the rect zone snap resolver: channels, registers and zone table.
//
// Requests arrive on the req_ stream. req_tuser selects a load (0), which writes
// one zone slot, or a query (1), which snaps a screen point into the zone table.
// Each request gives exactly one result on the rsp_ stream; rsp_tuser flags a
// snapped point. Loads and queries whose point is -1 or -2 in either coordinate
// complete at once: the result is valid in the cycle after acceptance, so such
// requests can follow one another on every cycle while the receiver takes each
// result. Other queries scan the table through the single read port of the zone
// memory and one shared compare unit, a second time only if a zone contains the
// point; the zone count is limited to ZONES. In the second scan, each other
// containing zone that shares the owner's priority also passes through overlap,
// split and decide steps. The core returns to idle as the result is registered,
// so the next request can be accepted while the result is shown. req_tready is
// high only while no query is in progress and the result register is empty or
// being emptied, so a stalled receiver holds the block after at most one waiting
// result. The csr_ port writes origin and zone count; the user must write them
// only while idle, which the block does not enforce. Reset clears the registers
// and the control state; zone slots hold nothing meaningful until loaded.
module rect_zone_snap_resolver #(
   parameter int ZONES = rzsr_pkg::ZONES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // slot[3:0], left[13:4], top[23:14], width[34:24], height[45:35],
   // priority[53:46], target_left[63:54], target_top[73:64], point_x[85:74],
   // point_y[97:86], zero fill above
   input  logic [rzsr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // owner_slot[3:0], out_x[15:4], out_y[27:16], zero fill above
   output logic [rzsr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // snapped[0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [rzsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rzsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = ($clog2(ZONES + 1) > rzsr_pkg::COUNT_W) ?
                       $clog2(ZONES + 1) : rzsr_pkg::COUNT_W;
   localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;

   logic signed [11:0] origin_x_ff, origin_x_in;
   logic signed [11:0] origin_y_ff, origin_y_in;
   logic [4:0]         count_ff, count_in;
   logic signed [11:0] pt_x_ff;
   logic signed [11:0] pt_y_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_snap_ff, rsp_snap_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;
   logic signed [11:0] rsp_x_ff, rsp_x_in;
   logic signed [11:0] rsp_y_ff, rsp_y_in;

   logic               accept;
   logic               out_free;
   logic               is_load;
   logic               is_none;
   logic               start;
   logic               take;
   logic [3:0]         f_slot;
   logic signed [11:0] f_px;
   logic signed [11:0] f_py;
   logic [CW-1:0]      slot_ext;
   logic [CW-1:0]      count_ext;
   logic [CW-1:0]      limit;
   rzsr_pkg::zone_rec_type wr_zone;
   logic               mem_we;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   rzsr_pkg::zone_rec_type rd_data;
   logic signed [12:0] rx;
   logic signed [12:0] ry;
   rzsr_pkg::core_stat_type stat;

   function automatic logic signed [11:0] sat_add(input logic [9:0] tgt,
                                                  input logic signed [11:0] org);
      logic signed [12:0] sum;
      sum = $signed({3'b000, tgt}) + $signed({org[11], org});
      if (sum > rzsr_pkg::OUT_MAX) begin
         sat_add = rzsr_pkg::OUT_MAX[11:0];
      end else if (sum < rzsr_pkg::OUT_MIN) begin
         sat_add = rzsr_pkg::OUT_MIN[11:0];
      end else begin
         sat_add = sum[11:0];
      end
   endfunction

   assign f_slot          = req_tdata[3:0];
   assign wr_zone.box.left   = req_tdata[13:4];
   assign wr_zone.box.top    = req_tdata[23:14];
   assign wr_zone.box.width  = req_tdata[34:24];
   assign wr_zone.box.height = req_tdata[45:35];
   assign wr_zone.prio    = req_tdata[53:46];
   assign wr_zone.tgt_x   = req_tdata[63:54];
   assign wr_zone.tgt_y   = req_tdata[73:64];
   assign f_px            = $signed(req_tdata[85:74]);
   assign f_py            = $signed(req_tdata[97:86]);

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = stat.idle && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_load    = req_tuser == rzsr_pkg::MODE_LOAD;
   assign is_none    = (f_px == rzsr_pkg::PT_NONE_A) || (f_px == rzsr_pkg::PT_NONE_B) ||
                       (f_py == rzsr_pkg::PT_NONE_A) || (f_py == rzsr_pkg::PT_NONE_B);
   assign start      = accept && !is_load && !is_none;
   assign take       = stat.done && out_free;

   assign slot_ext  = CW'(f_slot);
   assign count_ext = CW'(count_ff);
   assign limit     = (count_ext > CW'(ZONES)) ? CW'(ZONES) : count_ext;
   assign mem_we    = accept && is_load && (slot_ext < CW'(ZONES));

   assign rx = $signed({f_px[11], f_px}) - $signed({origin_x_ff[11], origin_x_ff});
   assign ry = $signed({f_py[11], f_py}) - $signed({origin_y_ff[11], origin_y_ff});

   rzsr_zone_mem #(
      .ZONES (ZONES)
   ) u_zone_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (slot_ext[IW-1:0]),
      .wr_data (wr_zone),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rzsr_core #(
      .ZONES (ZONES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .rx      (rx),
      .ry      (ry),
      .limit   (limit),
      .take    (take),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (stat)
   );

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      count_in    = count_ff;
      if (csr_we) begin
         unique case (csr_index)
            rzsr_pkg::CSR_ORIGIN_X:   origin_x_in = $signed(csr_wdata[11:0]);
            rzsr_pkg::CSR_ORIGIN_Y:   origin_y_in = $signed(csr_wdata[11:0]);
            rzsr_pkg::CSR_ZONE_COUNT: count_in    = csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_snap_in = rsp_snap_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      if (accept && (is_load || is_none)) begin
         rsp_vld_in  = 1'b1;
         rsp_snap_in = 1'b0;
         rsp_slot_in = '0;
         rsp_x_in    = is_load ? 12'sd0 : f_px;
         rsp_y_in    = is_load ? 12'sd0 : f_py;
      end else if (take) begin
         rsp_vld_in  = 1'b1;
         rsp_snap_in = stat.found;
         rsp_slot_in = stat.found ? stat.slot : 4'd0;
         rsp_x_in    = stat.found ? sat_add(stat.tgt_x, origin_x_ff) : pt_x_ff;
         rsp_y_in    = stat.found ? sat_add(stat.tgt_y, origin_y_ff) : pt_y_ff;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         count_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         count_ff    <= count_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pt_x_ff <= f_px;
         pt_y_ff <= f_py;
      end
      rsp_snap_ff <= rsp_snap_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_snap_ff;
   assign rsp_tdata  = {4'b0000, rsp_y_ff, rsp_x_ff, rsp_slot_ff};

endmodule

@@ verif/rect_zone_snap_resolver_tb.sv @@
// Self-checking testbench for the rect zone snap resolver: directed table, then random phases.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ZONES = rzsr_pkg::ZONES_DEF;
   localparam int ITEMS = 1300;
   localparam logic [11:0] PT_MAX = 12'h7FF;
   localparam logic [11:0] PT_MIN = 12'h800;

   typedef struct packed {
      logic        mode;
      logic [3:0]  slot;
      logic [9:0]  left;
      logic [9:0]  top;
      logic [10:0] width;
      logic [10:0] height;
      logic [7:0]  prio;
      logic [9:0]  tgt_x;
      logic [9:0]  tgt_y;
      logic [11:0] px;
      logic [11:0] py;
   } snap_req_type;

   typedef struct packed {
      logic        snapped;
      logic [3:0]  owner;
      logic [11:0] out_x;
      logic [11:0] out_y;
   } snap_res_type;

   typedef struct packed {
      bit           is_cfg;
      logic [11:0]  cfg_ox;
      logic [11:0]  cfg_oy;
      logic [4:0]   cfg_count;
      snap_req_type rq;
      bit           fixed;
      snap_res_type res;
   } step_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rzsr_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rzsr_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_we = 1'b0;
   logic [rzsr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rzsr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   rzsr_pkg::zone_rec_type zone_tab [ZONES];
   logic [11:0]  org_x = '0;
   logic [11:0]  org_y = '0;
   logic [4:0]   zone_cnt = '0;
   snap_res_type pending_snaps [$];
   step_row_type plan [$];
   int           err_count = 0;
   bit           steady = 1'b0;
   bit           hold_ask = 1'b0;

   rect_zone_snap_resolver #(.ZONES(ZONES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_owner(int rx, int ry);
      int lx [ZONES];
      int ty [ZONES];
      int rgt [ZONES];
      int btm [ZONES];
      int pr [ZONES];
      int cand [$];
      int limit, owner, o, ax, ay, bx, by, ow, oh;
      for (int i = 0; i < ZONES; i++) begin
         lx[i] = zone_tab[i].box.left;
         ty[i] = zone_tab[i].box.top;
         rgt[i] = lx[i] + int'(zone_tab[i].box.width);
         btm[i] = ty[i] + int'(zone_tab[i].box.height);
         pr[i] = zone_tab[i].prio;
      end
      limit = (zone_cnt > ZONES) ? ZONES : int'(zone_cnt);
      for (int i = 0; i < limit; i++)
         if (rx >= lx[i] && rx < rgt[i] && ry >= ty[i] && ry < btm[i])
            cand.insert(cand.size(), i);
      if (cand.size() == 0) return -1;
      owner = cand[0];
      foreach (cand[k])
         if (pr[cand[k]] > pr[owner]) owner = cand[k];
      foreach (cand[k]) begin
         o = cand[k];
         if (o == owner || pr[o] != pr[owner]) continue;
         ax = (lx[owner] > lx[o]) ? lx[owner] : lx[o];
         ay = (ty[owner] > ty[o]) ? ty[owner] : ty[o];
         bx = (rgt[owner] < rgt[o]) ? rgt[owner] : rgt[o];
         by = (btm[owner] < btm[o]) ? btm[owner] : btm[o];
         ow = bx - ax;
         oh = by - ay;
         if (ow <= 0 || oh <= 0) continue;
         if (!(rx >= ax && rx < bx && ry >= ay && ry < by)) continue;
         if (ow > oh) begin
            if (rx >= ax + ow / 2) begin
               if (lx[o] > lx[owner]) owner = o;
            end else begin
               if (lx[o] < lx[owner]) owner = o;
            end
         end else begin
            if (ry >= ay + oh / 2) begin
               if (ty[o] > ty[owner]) owner = o;
            end else begin
               if (ty[o] < ty[owner]) owner = o;
            end
         end
      end
      return owner;
   endfunction

   function automatic snap_res_type resolve_snap(snap_req_type r);
      snap_res_type res;
      int px, py, ox, oy, owner, sx, sy;
      res = '0;
      if (r.mode == rzsr_pkg::MODE_LOAD) begin
         zone_tab[r.slot].box.left = r.left;
         zone_tab[r.slot].box.top = r.top;
         zone_tab[r.slot].box.width = r.width;
         zone_tab[r.slot].box.height = r.height;
         zone_tab[r.slot].prio = r.prio;
         zone_tab[r.slot].tgt_x = r.tgt_x;
         zone_tab[r.slot].tgt_y = r.tgt_y;
         return res;
      end
      px = $signed(r.px);
      py = $signed(r.py);
      ox = $signed(org_x);
      oy = $signed(org_y);
      owner = -1;
      if (px != -1 && px != -2 && py != -1 && py != -2) owner = find_owner(px - ox, py - oy);
      if (owner < 0) begin
         res.out_x = r.px;
         res.out_y = r.py;
      end else begin
         sx = int'(zone_tab[owner].tgt_x) + ox;
         sy = int'(zone_tab[owner].tgt_y) + oy;
         if (sx > rzsr_pkg::OUT_MAX) sx = rzsr_pkg::OUT_MAX;
         if (sx < rzsr_pkg::OUT_MIN) sx = rzsr_pkg::OUT_MIN;
         if (sy > rzsr_pkg::OUT_MAX) sy = rzsr_pkg::OUT_MAX;
         if (sy < rzsr_pkg::OUT_MIN) sy = rzsr_pkg::OUT_MIN;
         res.snapped = 1'b1;
         res.owner = 4'(owner);
         res.out_x = 12'(sx);
         res.out_y = 12'(sy);
      end
      return res;
   endfunction

   function automatic logic [rzsr_pkg::REQ_TDATA_W-1:0] pack_request(snap_req_type r);
      return {6'd0, r.py, r.px, r.tgt_y, r.tgt_x, r.prio, r.height, r.width, r.top, r.left,
              r.slot};
   endfunction

   function automatic snap_req_type rand_request();
      snap_req_type r;
      int k, s, rx, ry, lim, ox, oy;
      r.mode = ($urandom_range(0, 99) < 25) ? rzsr_pkg::MODE_LOAD : rzsr_pkg::MODE_QUERY;
      r.slot = 4'($urandom);
      r.left = 10'($urandom);
      r.top = 10'($urandom);
      r.width = 11'($urandom_range(0, 1024));
      r.height = 11'($urandom_range(0, 1024));
      r.prio = 8'($urandom);
      r.tgt_x = 10'($urandom);
      r.tgt_y = 10'($urandom);
      r.px = 12'($urandom);
      r.py = 12'($urandom);
      k = $urandom_range(0, 99);
      if (r.mode == rzsr_pkg::MODE_LOAD) begin
         if (k < 70) begin
            r.left = 10'($urandom_range(0, 300));
            r.top = 10'($urandom_range(0, 300));
            r.width = 11'($urandom_range(1, 400));
            r.height = 11'($urandom_range(1, 400));
            r.prio = 8'($urandom_range(0, 2));
         end else if (k < 85) begin
            r.width = 11'd1024;
            r.height = 11'd1024;
         end
      end else begin
         lim = (zone_cnt > ZONES) ? ZONES : int'(zone_cnt);
         ox = $signed(org_x);
         oy = $signed(org_y);
         if (k < 5) begin
            r.px = k[0] ? rzsr_pkg::PT_NONE_A : rzsr_pkg::PT_NONE_B;
         end else if (k < 10) begin
            r.py = k[0] ? rzsr_pkg::PT_NONE_A : rzsr_pkg::PT_NONE_B;
         end else if (k >= 25) begin
            if (k < 45 || lim == 0) begin
               rx = $urandom_range(0, 700);
               ry = $urandom_range(0, 700);
            end else begin
               s = $urandom_range(0, lim - 1);
               rx = int'(zone_tab[s].box.left) + $urandom_range(0, zone_tab[s].box.width);
               ry = int'(zone_tab[s].box.top) + $urandom_range(0, zone_tab[s].box.height);
            end
            r.px = 12'(rx + ox);
            r.py = 12'(ry + oy);
         end
      end
      return r;
   endfunction

   function automatic void add_cfg(int ox, int oy, int cnt);
      step_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_ox = 12'(ox);
      row.cfg_oy = 12'(oy);
      row.cfg_count = 5'(cnt);
      plan.insert(plan.size(), row);
   endfunction

   function automatic void add_load(int slot, int l, int t, int w, int h, int p, int tx, int ty);
      step_row_type row;
      row = '0;
      row.rq.mode = rzsr_pkg::MODE_LOAD;
      row.rq.slot = 4'(slot);
      row.rq.left = 10'(l);
      row.rq.top = 10'(t);
      row.rq.width = 11'(w);
      row.rq.height = 11'(h);
      row.rq.prio = 8'(p);
      row.rq.tgt_x = 10'(tx);
      row.rq.tgt_y = 10'(ty);
      row.fixed = 1'b1;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void add_query(int px, int py, bit fixed, int sn, int sl, int ex, int ey);
      step_row_type row;
      row = '0;
      row.rq.mode = rzsr_pkg::MODE_QUERY;
      row.rq.px = 12'(px);
      row.rq.py = 12'(py);
      row.fixed = fixed;
      row.res.snapped = 1'(sn);
      row.res.owner = 4'(sl);
      row.res.out_x = 12'(ex);
      row.res.out_y = 12'(ey);
      plan.insert(plan.size(), row);
   endfunction

   task automatic offer_request(snap_req_type r, bit fixed, snap_res_type fixed_res);
      snap_res_type want;
      if (!steady) begin
         while ($urandom_range(0, 99) < 25) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tdata <= pack_request(r);
      req_tuser <= r.mode;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      want = resolve_snap(r);
      pending_snaps.insert(pending_snaps.size(), fixed ? fixed_res : want);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_snaps.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_regs(logic [11:0] ox, logic [11:0] oy, logic [4:0] cnt);
      csr_we <= 1'b1;
      csr_index <= rzsr_pkg::CSR_ORIGIN_X;
      csr_wdata <= ox;
      @(posedge clock);
      csr_index <= rzsr_pkg::CSR_ORIGIN_Y;
      csr_wdata <= oy;
      @(posedge clock);
      csr_index <= rzsr_pkg::CSR_ZONE_COUNT;
      csr_wdata <= {7'd0, cnt};
      @(posedge clock);
      csr_we <= 1'b0;
      org_x = ox;
      org_y = oy;
      zone_cnt = cnt;
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 25);
         end
      end
   end

   initial begin
      snap_res_type got, want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.snapped = rsp_tuser;
            got.owner = rsp_tdata[3:0];
            got.out_x = rsp_tdata[15:4];
            got.out_y = rsp_tdata[27:16];
            @(posedge clock);
            if (pending_snaps.size() == 0) begin
               $error("result with no request waiting");
               err_count++;
            end else begin
               want = pending_snaps.pop_front();
               if (got.snapped !== want.snapped) begin
                  $error("snapped: expected %0d, actual %0d", want.snapped, got.snapped);
                  err_count++;
               end
               if (got.owner !== want.owner) begin
                  $error("owner_slot: expected %0d, actual %0d", want.owner, got.owner);
                  err_count++;
               end
               if (got.out_x !== want.out_x) begin
                  $error("out_x: expected %0d, actual %0d", $signed(want.out_x),
                         $signed(got.out_x));
                  err_count++;
               end
               if (got.out_y !== want.out_y) begin
                  $error("out_y: expected %0d, actual %0d", $signed(want.out_y),
                         $signed(got.out_y));
                  err_count++;
               end
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("rect_zone_snap_resolver regression: fail");
      $finish;
   end

   initial begin
      snap_req_type r;
      snap_res_type nil;
      int           sent, phase, len, pick;
      logic [11:0]  ox, oy;
      logic [4:0]   cnt;
      nil = '0;
      foreach (zone_tab[i]) zone_tab[i] = '0;

      add_query(0, 0, 1'b1, 0, 0, 0, 0);
      add_query(-1, 100, 1'b1, 0, 0, -1, 100);
      add_query(300, -2, 1'b1, 0, 0, 300, -2);
      add_query(2047, -2048, 1'b1, 0, 0, 2047, -2048);
      add_load(0, 0, 0, 1024, 1024, 0, 1023, 1023);
      add_load(1, 1023, 1023, 1, 1, 255, 0, 0);
      add_load(2, 100, 100, 200, 100, 10, 5, 6);
      add_load(3, 200, 150, 200, 100, 10, 700, 800);
      add_load(4, 0, 0, 0, 0, 255, 1023, 0);
      add_load(5, 250, 120, 40, 120, 10, 3, 3);
      add_cfg(0, 0, 6);
      add_query(0, 0, 1'b0, 0, 0, 0, 0);
      add_query(1023, 1023, 1'b1, 1, 1, 0, 0);
      add_query(260, 160, 1'b0, 0, 0, 0, 0);
      add_query(240, 160, 1'b0, 0, 0, 0, 0);
      add_query(270, 190, 1'b0, 0, 0, 0, 0);
      add_query(-5, 3, 1'b1, 0, 0, -5, 3);
      add_query(-2, -2, 1'b1, 0, 0, -2, -2);
      add_cfg(2047, 2047, 6);
      add_query(2047, 2047, 1'b1, 1, 0, 2047, 2047);
      add_cfg(-2048, -2048, 6);
      add_query(-1025, -1025, 1'b0, 0, 0, 0, 0);
      add_query(-2048, -2048, 1'b0, 0, 0, 0, 0);
      add_query(-1, -1, 1'b1, 0, 0, -1, -1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            drain();
            write_regs(plan[i].cfg_ox, plan[i].cfg_oy, plan[i].cfg_count);
         end else begin
            offer_request(plan[i].rq, plan[i].fixed, plan[i].res);
         end
      end

      // Every slot is loaded before any count can reach it.
      for (int s = 0; s < ZONES; s++) begin
         r = rand_request();
         r.mode = rzsr_pkg::MODE_LOAD;
         r.slot = 4'(s);
         offer_request(r, 1'b0, nil);
      end

      sent = 0;
      phase = 0;
      while (sent < ITEMS) begin
         drain();
         case (phase)
            0: begin
               ox = PT_MAX;
               oy = PT_MAX;
               cnt = 5'd16;
            end
            1: begin
               ox = PT_MIN;
               oy = PT_MIN;
               cnt = 5'd31;
            end
            2: begin
               ox = '0;
               oy = '0;
               cnt = '0;
            end
            default: begin
               ox = 12'($urandom);
               oy = 12'($urandom);
               if ($urandom_range(0, 1) == 1) begin
                  ox = 12'($urandom_range(0, 200));
                  oy = 12'($urandom_range(0, 200));
               end
               pick = $urandom_range(0, 7);
               if (pick == 0) cnt = 5'd0;
               else if (pick == 1) cnt = 5'($urandom_range(17, 31));
               else cnt = 5'($urandom_range(1, 16));
            end
         endcase
         write_regs(ox, oy, cnt);
         steady = (phase == 4);
         if (phase == 7) hold_ask = 1'b1;
         len = $urandom_range(40, 90);
         repeat (len) begin
            r = rand_request();
            offer_request(r, 1'b0, nil);
            sent++;
         end
         phase++;
      end
      steady = 1'b0;
      drain();
      repeat (100) @(posedge clock);

      if (err_count == 0) begin
         $display("rect_zone_snap_resolver regression: pass");
      end else begin
         $display("rect_zone_snap_resolver regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rzsr_pkg.sv
hw/rtl/rzsr_zone_mem.sv
hw/rtl/rzsr_geom.sv
hw/rtl/rzsr_core.sv
hw/rtl/rect_zone_snap_resolver.sv
verif/rect_zone_snap_resolver_tb.sv
